// ===== rtl/core/fqs_pkg.sv =====
// Shared types and codes for the FIFO queue with membership search.
package fqs_pkg;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 32;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_POP_READ,
      SEQ_SCAN
   } fqs_state_type;

endpackage

// ===== rtl/core/fqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fifo_queue_with_search_core.sv =====
// Top level of the FIFO queue with membership search: sequencer, pointers and store.
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+--------------------------
//   request  | req_cmd, req_value                             | start high, busy low
//   response | rsp_head_value, rsp_found, rsp_status,         | rsp_strobe, one cycle,
//            | rsp_is_empty                                   | no back pressure
//
// Sequencer states per transaction, from acceptance to the strobe:
//   push, unused code, pop on empty, search on empty: answered from EXEC.
//   pop: EXEC, then POP_READ for the registered read of the store.
//   search: EXEC, then SCAN over k entries compared before a match or the tail (1..depth);
//   the single store read port and the one comparator make the walk go one entry at a time.
// busy stays high from the accepting edge until the response is strobed; a new
// transaction may be accepted in the strobe cycle itself.
// reset is synchronous and clears the pointers, the entry count and the sequencer.
// The store itself is not cleared: no command can read a slot before it was written.
module fifo_queue_with_search_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [fqs_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [fqs_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_strobe,
   output logic signed [fqs_pkg::VALUE_W-1:0] rsp_head_value,
   output logic                               rsp_found,
   output logic [fqs_pkg::STATUS_W-1:0]       rsp_status,
   output logic                               rsp_is_empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] ONE_COUNT  = CNT_W'(1);

   // Step a ring pointer, wrapping from the last slot back to zero.
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
      next_slot = (slot == LAST_SLOT) ? '0 : slot + PTR_W'(1);
   endfunction

   fqs_pkg::fqs_state_type state_ff, state_in;

   logic [fqs_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0]        value_ff, value_in;
   logic [PTR_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [PTR_W-1:0]             scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]             left_ff, left_in;

   logic                         strobe_ff, strobe_in;
   logic [fqs_pkg::VALUE_W-1:0]  head_ff, head_in;
   logic                         found_ff, found_in;
   logic [fqs_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         empty_ff, empty_in;

   // Store port signals.
   logic                         ram_we;
   logic [PTR_W-1:0]             ram_raddr;
   logic [DATA_WIDTH-1:0]        ram_rdata;
   logic                         match;

   fqs_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (value_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The one comparator: store word against the held operand.
   assign match = (ram_rdata == value_ff);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      value_in    = value_ff;
      rd_ptr_in   = rd_ptr_ff;
      wr_ptr_in   = wr_ptr_ff;
      count_in    = count_ff;
      scan_ptr_in = scan_ptr_ff;
      left_in     = left_ff;
      strobe_in   = 1'b0;
      head_in     = head_ff;
      found_in    = found_ff;
      status_in   = status_ff;
      empty_in    = empty_ff;
      ram_we      = 1'b0;
      ram_raddr   = rd_ptr_ff;

      case (state_ff)
         fqs_pkg::SEQ_IDLE: begin
            // Capture the transaction; keep only the stored width of the value.
            if (start) begin
               cmd_in   = req_cmd;
               value_in = DATA_WIDTH'($unsigned(req_value));
               state_in = fqs_pkg::SEQ_EXEC;
            end
         end

         fqs_pkg::SEQ_EXEC: begin
            case (cmd_ff)
               fqs_pkg::CMD_PUSH: begin
                  head_in   = '0;
                  found_in  = 1'b0;
                  strobe_in = 1'b1;
                  state_in  = fqs_pkg::SEQ_IDLE;
                  if (count_ff == FULL_COUNT) begin
                     // Drop the value, leave the queue as it is.
                     status_in = fqs_pkg::STATUS_PUSH_FULL;
                     empty_in  = 1'b0;
                  end else begin
                     ram_we    = 1'b1;
                     wr_ptr_in = next_slot(wr_ptr_ff);
                     count_in  = count_ff + ONE_COUNT;
                     status_in = fqs_pkg::STATUS_OK;
                     empty_in  = 1'b0;
                  end
               end

               fqs_pkg::CMD_POP: begin
                  if (count_ff == '0) begin
                     head_in   = '0;
                     found_in  = 1'b0;
                     status_in = fqs_pkg::STATUS_POP_EMPTY;
                     empty_in  = 1'b1;
                     strobe_in = 1'b1;
                     state_in  = fqs_pkg::SEQ_IDLE;
                  end else begin
                     // Read the head slot; data lands next cycle.
                     ram_raddr = rd_ptr_ff;
                     state_in  = fqs_pkg::SEQ_POP_READ;
                  end
               end

               fqs_pkg::CMD_SEARCH: begin
                  if (count_ff == '0) begin
                     head_in   = '0;
                     found_in  = 1'b0;
                     status_in = fqs_pkg::STATUS_OK;
                     empty_in  = 1'b1;
                     strobe_in = 1'b1;
                     state_in  = fqs_pkg::SEQ_IDLE;
                  end else begin
                     // Start the walk at the head; prefetch one slot ahead.
                     ram_raddr   = rd_ptr_ff;
                     scan_ptr_in = next_slot(rd_ptr_ff);
                     left_in     = count_ff;
                     state_in    = fqs_pkg::SEQ_SCAN;
                  end
               end

               default: begin
                  // Unused code: report the current fill state only.
                  head_in   = '0;
                  found_in  = 1'b0;
                  status_in = fqs_pkg::STATUS_OK;
                  empty_in  = (count_ff == '0);
                  strobe_in = 1'b1;
                  state_in  = fqs_pkg::SEQ_IDLE;
               end
            endcase
         end

         fqs_pkg::SEQ_POP_READ: begin
            head_in   = fqs_pkg::VALUE_W'(ram_rdata);
            found_in  = 1'b0;
            status_in = fqs_pkg::STATUS_OK;
            empty_in  = (count_ff == ONE_COUNT);
            rd_ptr_in = next_slot(rd_ptr_ff);
            count_in  = count_ff - ONE_COUNT;
            strobe_in = 1'b1;
            state_in  = fqs_pkg::SEQ_IDLE;
         end

         fqs_pkg::SEQ_SCAN: begin
            if (match || left_ff == ONE_COUNT) begin
               // Stop on the first hit or after the tail entry.
               head_in   = '0;
               found_in  = match;
               status_in = fqs_pkg::STATUS_OK;
               empty_in  = 1'b0;
               strobe_in = 1'b1;
               state_in  = fqs_pkg::SEQ_IDLE;
            end else begin
               // Advance to the next entry toward the tail.
               ram_raddr   = scan_ptr_ff;
               scan_ptr_in = next_slot(scan_ptr_ff);
               left_in     = left_ff - ONE_COUNT;
            end
         end

         default: begin
            state_in = fqs_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fqs_pkg::SEQ_IDLE;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // Operand, walk and response payload: no reset needed.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      value_ff    <= value_in;
      scan_ptr_ff <= scan_ptr_in;
      left_ff     <= left_in;
      head_ff     <= head_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      empty_ff    <= empty_in;
   end

   assign busy           = (state_ff != fqs_pkg::SEQ_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_head_value = head_ff;
   assign rsp_found      = found_ff;
   assign rsp_status     = status_ff;
   assign rsp_is_empty   = empty_ff;

endmodule

// ===== rtl/core/fqs_checker.sv =====
// Port-level checker for the FIFO queue with membership search, and its bind.
module fqs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_strobe,
   input logic signed [fqs_pkg::VALUE_W-1:0] rsp_head_value,
   input logic                               rsp_found,
   input logic [fqs_pkg::STATUS_W-1:0]       rsp_status,
   input logic                               rsp_is_empty
);

   // An accepted transaction keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // A response only ends a busy period, and the block is free while it shows.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("response strobe outside the end of a transaction");

   // Pop on empty returns zero and reports the queue empty.
   a_underflow: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == fqs_pkg::STATUS_POP_EMPTY)
         |-> (rsp_is_empty && rsp_head_value == '0 && !rsp_found))
      else $error("bad underflow response");

   // A hit implies a non-empty queue and a clean status.
   a_found_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found)
         |-> (!rsp_is_empty && rsp_status == fqs_pkg::STATUS_OK))
      else $error("search hit on an empty queue or with bad status");

endmodule

bind fifo_queue_with_search_core fqs_checker u_fqs_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_head_value (rsp_head_value),
   .rsp_found      (rsp_found),
   .rsp_status     (rsp_status),
   .rsp_is_empty   (rsp_is_empty)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for the FIFO queue with search: directed and random commands checked against a mirror.
module testbench;

   localparam int QUEUE_DEPTH = 16;
   localparam int DATA_WIDTH  = 32;

   // Command code 3 is unused by the block and must act as a no-op.
   localparam logic [fqs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_TIME  = 40;    // longest search plus margin
   localparam int RANDOM_ITEMS = 1325;
   localparam int CALM_ITEMS   = 200;   // final stretch without sender gaps
   localparam int MAX_PRINTS   = 40;

   typedef struct {
      logic signed [fqs_pkg::VALUE_W-1:0] head_value;
      logic                               found;
      logic [fqs_pkg::STATUS_W-1:0]       status;
      logic                               is_empty;
   } queue_result_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               start = 1'b0;
   logic                               busy;
   logic [fqs_pkg::CMD_W-1:0]          req_cmd = fqs_pkg::CMD_PUSH;
   logic signed [fqs_pkg::VALUE_W-1:0] req_value = '0;
   logic                               rsp_strobe;
   logic signed [fqs_pkg::VALUE_W-1:0] rsp_head_value;
   logic                               rsp_found;
   logic [fqs_pkg::STATUS_W-1:0]       rsp_status;
   logic                               rsp_is_empty;

   // Mirror of the queue contents, updated at each accepted transaction.
   logic [fqs_pkg::VALUE_W-1:0] mirror_store [QUEUE_DEPTH];
   logic [3:0]                  mirror_head = '0;
   logic [3:0]                  mirror_tail = '0;
   int                          mirror_count = 0;

   queue_result_type            pending_results [$];
   logic [fqs_pkg::VALUE_W-1:0] value_pool [8];
   int                          error_count = 0;
   int                          cycle_count = 0;
   bit                          gaps_enabled = 1'b0;

   fifo_queue_with_search_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_head_value (rsp_head_value),
      .rsp_found      (rsp_found),
      .rsp_status     (rsp_status),
      .rsp_is_empty   (rsp_is_empty)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Apply one command to the mirror and return the response it must produce.
   function automatic queue_result_type apply_queue_command(
         input logic [fqs_pkg::CMD_W-1:0] cmd, input logic [fqs_pkg::VALUE_W-1:0] value);
      queue_result_type outcome;
      logic [3:0]       slot;
      outcome.head_value = '0;
      outcome.found      = 1'b0;
      outcome.status     = fqs_pkg::STATUS_OK;
      case (cmd)
         fqs_pkg::CMD_PUSH: begin
            if (mirror_count == QUEUE_DEPTH) begin
               outcome.status = fqs_pkg::STATUS_PUSH_FULL;
            end else begin
               mirror_store[mirror_tail] = value;
               mirror_tail  = mirror_tail + 4'd1;
               mirror_count = mirror_count + 1;
            end
         end
         fqs_pkg::CMD_POP: begin
            if (mirror_count == 0) begin
               outcome.status = fqs_pkg::STATUS_POP_EMPTY;
            end else begin
               outcome.head_value = mirror_store[mirror_head];
               mirror_head  = mirror_head + 4'd1;
               mirror_count = mirror_count - 1;
            end
         end
         fqs_pkg::CMD_SEARCH: begin
            slot = mirror_head;
            for (int k = 0; k < mirror_count; k++) begin
               if (mirror_store[slot] == value) outcome.found = 1'b1;
               slot = slot + 4'd1;
            end
         end
         default: ;
      endcase
      outcome.is_empty = (mirror_count == 0);
      return outcome;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_PRINTS)
         $display("mismatch on %s at cycle %0d: got %h, expected %h",
                  what, cycle_count, got, want);
   endtask

   // Compare every strobed response with the oldest expectation.
   always @(posedge clock) begin : check_responses
      queue_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_head_value, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_head_value !== want.head_value)
               report_mismatch("head_value", rsp_head_value, want.head_value);
            if (rsp_found !== want.found)
               report_mismatch("found", 32'(rsp_found), 32'(want.found));
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_is_empty !== want.is_empty)
               report_mismatch("is_empty", 32'(rsp_is_empty), 32'(want.is_empty));
         end
      end
   end

   // Hold start high until the transaction is taken; leave it high unless a gap follows,
   // so back-to-back transactions never see start dropped and raised in one step.
   task automatic send_command(input logic [fqs_pkg::CMD_W-1:0] cmd,
                               input logic [fqs_pkg::VALUE_W-1:0] value);
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(apply_queue_command(cmd, value));
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Drop start and hold until every outstanding response has come back.
   task automatic wait_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic logic [fqs_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         1, 2, 3: return value_pool[3'($urandom_range(0, 7))];
         default: return $urandom;
      endcase
   endfunction

   // Favor values that are currently stored, so searches hit at every depth.
   function automatic logic [fqs_pkg::VALUE_W-1:0] pick_search_value();
      logic [3:0] offset;
      if (mirror_count > 0 && $urandom_range(0, 1) == 0) begin
         offset = 4'($urandom_range(0, mirror_count - 1));
         return mirror_store[mirror_head + offset];
      end
      return pick_value();
   endfunction

   task automatic test_empty_queue();
      send_command(fqs_pkg::CMD_POP, $urandom);
      send_command(fqs_pkg::CMD_SEARCH, $urandom);
      send_command(CMD_UNUSED, $urandom);
   endtask

   task automatic test_extreme_values();
      send_command(fqs_pkg::CMD_PUSH, 32'h7FFF_FFFF);
      send_command(fqs_pkg::CMD_PUSH, 32'h8000_0000);
      send_command(fqs_pkg::CMD_SEARCH, 32'h8000_0000);
      send_command(fqs_pkg::CMD_POP, $urandom);
   endtask

   // Fill to the brim, try one more push, scan the full store for a missing value, then send the unused code.
   task automatic test_full_queue();
      int fill;
      fill = 1;
      while (mirror_count < QUEUE_DEPTH) begin
         send_command(fqs_pkg::CMD_PUSH, 32'(fill));
         fill++;
      end
      send_command(fqs_pkg::CMD_PUSH, 32'hFFFF_FFFF);
      send_command(fqs_pkg::CMD_SEARCH, 32'h1234_5678);
      send_command(CMD_UNUSED, $urandom);
   endtask

   // Segments lean toward filling, draining or balance, so the pointers wrap often and
   // both the full and the empty corner are hit many times.
   task automatic test_random_traffic();
      int                          segment_left;
      int                          push_weight;
      bit                          segment_gaps;
      int                          roll;
      logic [fqs_pkg::CMD_W-1:0]   cmd;
      logic [fqs_pkg::VALUE_W-1:0] value;
      segment_left = 0;
      push_weight  = 50;
      segment_gaps = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (segment_left == 0) begin
            segment_left = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
               0: push_weight = 70;
               1: push_weight = 25;
               default: push_weight = 45;
            endcase
            segment_gaps = $urandom_range(0, 3) != 0;
            value_pool[3'($urandom_range(0, 7))] = $urandom;
         end
         segment_left--;
         gaps_enabled = segment_gaps && (n < RANDOM_ITEMS - CALM_ITEMS);
         if (n == RANDOM_ITEMS / 2) wait_until_drained();
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            cmd   = CMD_UNUSED;
            value = $urandom;
         end else if (roll < 25) begin
            cmd   = fqs_pkg::CMD_SEARCH;
            value = pick_search_value();
         end else if ($urandom_range(0, 99) < push_weight) begin
            cmd   = fqs_pkg::CMD_PUSH;
            value = pick_value();
         end else begin
            cmd   = fqs_pkg::CMD_POP;
            value = $urandom;
         end
         send_command(cmd, value);
      end
      gaps_enabled = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < 8; i++) value_pool[i] = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_extreme_values();
      test_full_queue();
      test_random_traffic();
      wait_until_drained();
      repeat (SETTLE_TIME) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
